// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/dfe_pkg.sv -----
// Package with the word types, framing codes and CRC-8 step of the frame encoder.
`default_nettype none
package dfe_pkg;

    localparam logic [7:0] DLE      = 8'h10;
    localparam logic [7:0] STX      = 8'h02;
    localparam logic [7:0] ETX      = 8'h03;
    localparam logic [7:0] CRC_POLY = 8'h8c;
    localparam logic [7:0] LSB_MASK = 8'h01;

    // Most result words one input word can cause: DLE STX, stuffed byte, stuffed CRC, DLE ETX.
    localparam int MAX_RUN = 8;
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);
    localparam int RUN_IDX_W = $clog2(MAX_RUN);

    typedef struct packed {
        logic [7:0] body_byte;
        logic       first_flag;
        logic       last_flag;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_out_word;

    // The run of wire bytes caused by one input word, first byte in entry zero.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    cnt;
        logic                    close;
    } t_run;

    // One byte of the reflected CRC-8, least significant bit first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] data;
        logic       fb;
        crc  = crc_in;
        data = data_in;
        for (int i = 0; i < 8; i++) begin
            fb   = crc[0] ^ data[0];
            crc  = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
            data = data >> 1;
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

// ----- design/dfe_stream_if.sv -----
// Valid/ready stream interface that carries one word of a given type.
`default_nettype none
interface dfe_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/dfe_expand.sv -----
// Expands one input word into its run of stuffed wire bytes and the next CRC and frame state.
`default_nettype none
module dfe_expand (
    input  var dfe_pkg::t_in_word i_word,
    input  var logic [7:0]        i_crc,
    input  var logic              i_in_frame,
    output dfe_pkg::t_run         o_run,
    output logic [7:0]            o_crc,
    output logic                  o_in_frame
);

    always_comb begin
        logic [dfe_pkg::RUN_CNT_W-1:0] n;
        logic [7:0]                    crc;
        logic                          open;
        n     = '0;
        crc   = i_crc;
        open  = i_in_frame;
        o_run = '0;

        if (i_word.first_flag) begin
            o_run.bytes[n[dfe_pkg::RUN_IDX_W-1:0]] = dfe_pkg::DLE;
            n = n + 1'b1;
            o_run.bytes[n[dfe_pkg::RUN_IDX_W-1:0]] = dfe_pkg::STX;
            n = n + 1'b1;
            crc  = '0;
            open = 1'b1;
        end

        if (open) begin
            if (i_word.body_byte == dfe_pkg::DLE) begin
                o_run.bytes[n[dfe_pkg::RUN_IDX_W-1:0]] = dfe_pkg::DLE;
                n = n + 1'b1;
            end
            o_run.bytes[n[dfe_pkg::RUN_IDX_W-1:0]] = i_word.body_byte;
            n   = n + 1'b1;
            crc = dfe_pkg::crc8_update(crc, i_word.body_byte);

            if (i_word.last_flag) begin
                if (crc == dfe_pkg::DLE) begin
                    o_run.bytes[n[dfe_pkg::RUN_IDX_W-1:0]] = dfe_pkg::DLE;
                    n = n + 1'b1;
                end
                o_run.bytes[n[dfe_pkg::RUN_IDX_W-1:0]] = crc;
                n = n + 1'b1;
                o_run.bytes[n[dfe_pkg::RUN_IDX_W-1:0]] = dfe_pkg::DLE;
                n = n + 1'b1;
                o_run.bytes[n[dfe_pkg::RUN_IDX_W-1:0]] = dfe_pkg::ETX;
                n = n + 1'b1;
                open        = 1'b0;
                o_run.close = 1'b1;
            end
        end

        o_run.cnt  = n;
        o_crc      = crc;
        o_in_frame = open;
    end

endmodule
`default_nettype wire

// ----- design/dle_frame_encoder_crc8_core.sv -----
// Top level of the DLE/STX/ETX byte-stuffing frame encoder with CRC-8.
`default_nettype none
// The encoder takes the unstuffed body of a frame (type, length, payload) one word per
// handshake on i_in and sends the stuffed wire stream one byte per word on o_out. A word
// flagged first opens a frame with DLE STX; every body byte follows, a DLE byte sent twice;
// after the word flagged last come the Dallas/Maxim CRC-8 of the body (stuffed if it equals
// DLE) and DLE ETX, whose ETX word carries frame_end. run_last marks the final output word
// caused by each input word. A word without first_flag while no frame is open is taken and
// dropped. A first word inside an open frame abandons that frame without CRC or ETX.
// Timing: the input word is expanded combinationally and registered into a result buffer of
// up to eight bytes, which then drains one byte per cycle while o_out.ready is high. The next
// input word can be taken in the same cycle in which the last byte of the current run is taken,
// so the output side does not idle between runs while input words that yield bytes are offered.
module dle_frame_encoder_crc8_core (
    input  var logic     i_clk,
    input  var logic     i_rst_n,
    dfe_stream_if.sink   i_in,
    dfe_stream_if.source o_out
);

    // Running CRC and frame state, updated at the moment an input word is accepted.
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic       r_in_frame;
    logic       n_in_frame;

    // Result buffer: entry zero is the byte on the output, the rest shift down as it drains.
    logic [dfe_pkg::MAX_RUN-1:0][7:0] r_buf;
    logic [dfe_pkg::RUN_CNT_W-1:0]    r_cnt;
    logic                             r_close;

    dfe_pkg::t_run run;
    logic          in_take;
    logic          out_take;
    logic          run_tail;

    dfe_expand u_expand (
        .i_word     (i_in.data),
        .i_crc      (r_crc),
        .i_in_frame (r_in_frame),
        .o_run      (run),
        .o_crc      (n_crc),
        .o_in_frame (n_in_frame)
    );

    // The buffer holds the tail of its run when only one byte is left.
    assign run_tail = (r_cnt == dfe_pkg::RUN_CNT_W'(1));
    assign out_take = o_out.valid && o_out.ready;

    // A new word enters when the buffer is empty or its last byte leaves in this cycle.
    assign i_in.ready = (r_cnt == '0) || (run_tail && o_out.ready);
    assign in_take    = i_in.valid && i_in.ready;

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.data.out_byte  = r_buf[0];
    assign o_out.data.run_last  = run_tail;
    assign o_out.data.frame_end = run_tail && r_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= '0;
            r_in_frame <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (in_take) begin
                r_crc      <= n_crc;
                r_in_frame <= n_in_frame;
                r_cnt      <= run.cnt;
            end else if (out_take) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Payload of the buffer needs no reset; the count alone says what is valid.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_buf   <= run.bytes;
            r_close <= run.close;
        end else if (out_take) begin
            r_buf <= r_buf >> 8;
        end
    end

endmodule
`default_nettype wire

// ----- design/dfe_checker.sv -----
// Port-level checker for the frame encoder and the bind that attaches it.
`default_nettype none
`include "assert_macros.svh"
module dfe_checker (
    input var logic       i_clk,
    input var logic       i_rst_n,
    input var logic       i_in_valid,
    input var logic       i_in_ready,
    input var logic       i_first_flag,
    input var logic       i_out_valid,
    input var logic       i_out_ready,
    input var logic [7:0] i_out_byte,
    input var logic       i_run_last,
    input var logic       i_frame_end
);

    logic       out_stall;
    logic [9:0] out_word;
    logic       etx_out;
    logic       dle_out;
    logic       open_take;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_word  = {i_out_byte, i_run_last, i_frame_end};
    assign etx_out   = i_run_last && (i_out_byte == dfe_pkg::ETX);
    assign dle_out   = i_out_valid && (i_out_byte == dfe_pkg::DLE);
    assign open_take = i_in_valid && i_in_ready && i_first_flag;

    // A stalled output word stays offered and unchanged.
    `ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, out_stall, i_out_valid)
    `ASSERT_NEXT(a_out_word_hold, i_clk, i_rst_n, out_stall, $stable(out_word))

    // The closing ETX is the final word of its run.
    `ASSERT_IMPL(a_end_is_etx, i_clk, i_rst_n, i_out_valid && i_frame_end, etx_out)

    // A frame opening word puts DLE on the output in the next cycle.
    `ASSERT_NEXT(a_open_sends_dle, i_clk, i_rst_n, open_take, dle_out)

endmodule

bind dle_frame_encoder_crc8_core dfe_checker u_dfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_first_flag (i_in.data.first_flag),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.data.out_byte),
    .i_run_last   (o_out.data.run_last),
    .i_frame_end  (o_out.data.frame_end)
);
`default_nettype wire
